// ===== sv/mrs_pkg.sv =====
// Shared types and constants for the multichannel relay sequencer.
package mrs_pkg;

    // Fixed field widths
    localparam int OP_BITS     = 3;
    localparam int INDEX_BITS  = 3;
    localparam int LEN_BITS    = 32;
    localparam int SEC_BITS    = 16;
    localparam int CYCLE_BITS  = 16;
    localparam int MODE_BITS   = 2;
    localparam int LANE_BITS   = 8;

    localparam logic [LEN_BITS-1:0] MS_PER_SECOND = 32'd1000;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_BITS-1:0] OP_SET     = 3'd1;
    localparam logic [OP_BITS-1:0] OP_SET_ALL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_TIMER   = 3'd3;
    localparam logic [OP_BITS-1:0] OP_PULSE   = 3'd4;
    localparam logic [OP_BITS-1:0] OP_BLINK   = 3'd5;
    localparam logic [OP_BITS-1:0] OP_STATUS  = 3'd6;

    // Channel modes
    localparam logic [MODE_BITS-1:0] MODE_TOGGLE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_TIMER  = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_PULSE  = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_BLINK  = 2'd3;

    // One request
    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [INDEX_BITS-1:0] relay_index;
        logic                  level;
        logic [SEC_BITS-1:0]   timer_seconds;
        logic [LEN_BITS-1:0]   pulse_length_ms;
        logic [LEN_BITS-1:0]   on_phase_ms;
        logic [LEN_BITS-1:0]   off_phase_ms;
        logic [CYCLE_BITS-1:0] blink_cycles;
    } request_t;

    // One result
    typedef struct packed {
        logic [LANE_BITS-1:0] relays_on;
        logic [LANE_BITS-1:0] drive_pins;
        logic [LANE_BITS-1:0] changed_mask;
        logic                 status_on;
        logic [MODE_BITS-1:0] status_mode;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } dp_ctl_t;

endpackage

// ===== sv/mrs_ctrl.sv =====
// Request sequencing controller for the relay sequencer.
module mrs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    output logic            result_valid,
    input  logic            result_stall,
    output mrs_pkg::dp_ctl_t ctl
);
    import mrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   can_take;

    // A new request may enter when idle or when the held result leaves
    assign can_take     = (state_reg == ST_IDLE) ||
                          ((state_reg == ST_DONE) && !result_stall);
    assign cmd_stall    = !can_take;
    assign result_valid = (state_reg == ST_DONE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl.load   = 1'b0;
        ctl.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_stall)
                begin
                    if (cmd_valid)
                    begin
                        ctl.load   = 1'b1;
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/mrs_datapath.sv =====
// Per-channel relay state, tick and command execution, and result register.
module mrs_datapath #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  mrs_pkg::dp_ctl_t  ctl,
    input  mrs_pkg::request_t cmd,
    output mrs_pkg::result_t  result
);
    import mrs_pkg::*;

    localparam int CMP_BITS = (TIME_BITS > LEN_BITS) ? TIME_BITS : LEN_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Captured request
    request_t req_reg;

    // Channel state
    logic [MODE_BITS-1:0]  mode_reg      [CHANNELS];
    logic [MODE_BITS-1:0]  mode_next     [CHANNELS];
    logic [TIME_BITS-1:0]  elapsed_reg   [CHANNELS];
    logic [TIME_BITS-1:0]  elapsed_next  [CHANNELS];
    logic [LEN_BITS-1:0]   hold_reg      [CHANNELS];
    logic [LEN_BITS-1:0]   hold_next     [CHANNELS];
    logic [LEN_BITS-1:0]   on_len_reg    [CHANNELS];
    logic [LEN_BITS-1:0]   on_len_next   [CHANNELS];
    logic [LEN_BITS-1:0]   off_len_reg   [CHANNELS];
    logic [LEN_BITS-1:0]   off_len_next  [CHANNELS];
    logic [CYCLE_BITS-1:0] cycles_reg    [CHANNELS];
    logic [CYCLE_BITS-1:0] cycles_next   [CHANNELS];
    logic [CHANNELS-1:0]   active_reg, active_next;
    logic [CHANNELS-1:0]   phase_reg, phase_next;
    logic [CHANNELS-1:0]   level_reg, level_next;

    result_t              result_reg, result_next;
    logic [LEN_BITS-1:0]  timer_ms;
    logic                 idx_valid;

    assign timer_ms  = LEN_BITS'(LEN_BITS'(req_reg.timer_seconds) * MS_PER_SECOND);
    assign idx_valid = (LEN_BITS'(req_reg.relay_index) < LEN_BITS'(CHANNELS));

    // Channel updates, all channels in parallel
    always_comb
    begin
        logic [TIME_BITS-1:0]  inc;
        logic [CMP_BITS-1:0]   ecmp;
        logic [LEN_BITS-1:0]   plen;
        logic [CYCLE_BITS-1:0] cl;
        logic                  hit;
        for (int c = 0; c < CHANNELS; c++)
        begin
            mode_next[c]    = mode_reg[c];
            elapsed_next[c] = elapsed_reg[c];
            hold_next[c]    = hold_reg[c];
            on_len_next[c]  = on_len_reg[c];
            off_len_next[c] = off_len_reg[c];
            cycles_next[c]  = cycles_reg[c];
            active_next[c]  = active_reg[c];
            phase_next[c]   = phase_reg[c];
            level_next[c]   = level_reg[c];

            inc  = (elapsed_reg[c] == TIME_MAX) ? elapsed_reg[c] :
                   elapsed_reg[c] + TIME_BITS'(1);
            ecmp = CMP_BITS'(inc);
            plen = phase_reg[c] ? on_len_reg[c] : off_len_reg[c];
            cl   = (cycles_reg[c] != '0) ? cycles_reg[c] - CYCLE_BITS'(1) : cycles_reg[c];
            hit  = idx_valid && (req_reg.relay_index == INDEX_BITS'(c));

            case (req_reg.operation)
                OP_TICK:
                begin
                    if (active_reg[c])
                    begin
                        elapsed_next[c] = inc;
                        if ((mode_reg[c] == MODE_TIMER) || (mode_reg[c] == MODE_PULSE))
                        begin
                            if (ecmp >= CMP_BITS'(hold_reg[c]))
                            begin
                                active_next[c] = 1'b0;
                                level_next[c]  = 1'b0;
                            end
                        end
                        else if (mode_reg[c] == MODE_BLINK)
                        begin
                            if (ecmp >= CMP_BITS'(plen))
                            begin
                                elapsed_next[c] = '0;
                                if (phase_reg[c])
                                begin
                                    phase_next[c] = 1'b0;
                                    level_next[c] = 1'b0;
                                end
                                else
                                begin
                                    cycles_next[c] = cl;
                                    if (cl == '0)
                                    begin
                                        active_next[c] = 1'b0;
                                    end
                                    else
                                    begin
                                        phase_next[c] = 1'b1;
                                        level_next[c] = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
                OP_SET_ALL:
                begin
                    active_next[c] = 1'b0;
                    mode_next[c]   = MODE_TOGGLE;
                    level_next[c]  = req_reg.level;
                end
                OP_SET:
                begin
                    if (hit)
                    begin
                        active_next[c] = 1'b0;
                        mode_next[c]   = MODE_TOGGLE;
                        level_next[c]  = req_reg.level;
                    end
                end
                OP_TIMER:
                begin
                    if (hit)
                    begin
                        mode_next[c]    = MODE_TIMER;
                        active_next[c]  = 1'b1;
                        elapsed_next[c] = '0;
                        level_next[c]   = 1'b1;
                        hold_next[c]    = timer_ms;
                    end
                end
                OP_PULSE:
                begin
                    if (hit)
                    begin
                        mode_next[c]    = MODE_PULSE;
                        active_next[c]  = 1'b1;
                        elapsed_next[c] = '0;
                        level_next[c]   = 1'b1;
                        hold_next[c]    = req_reg.pulse_length_ms;
                    end
                end
                OP_BLINK:
                begin
                    if (hit)
                    begin
                        mode_next[c]    = MODE_BLINK;
                        active_next[c]  = 1'b1;
                        elapsed_next[c] = '0;
                        level_next[c]   = 1'b1;
                        on_len_next[c]  = req_reg.on_phase_ms;
                        off_len_next[c] = req_reg.off_phase_ms;
                        cycles_next[c]  = req_reg.blink_cycles;
                        phase_next[c]   = 1'b1;
                    end
                end
                OP_STATUS:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result from the updated state
    always_comb
    begin
        result_next              = '0;
        result_next.relays_on    = LANE_BITS'(level_next);
        result_next.drive_pins   = ~LANE_BITS'(level_next);
        result_next.changed_mask = LANE_BITS'(level_next ^ level_reg);
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (idx_valid && (req_reg.relay_index == INDEX_BITS'(c)))
            begin
                result_next.status_on   = level_next[c];
                result_next.status_mode = active_next[c] ? mode_next[c] : MODE_TOGGLE;
            end
        end
    end

    // Request capture and result register
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= cmd;
        end
        if (ctl.exec)
        begin
            result_reg <= result_next;
        end
    end

    // Durations and blink count are only read after a start writes them
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                hold_reg[c]    <= hold_next[c];
                on_len_reg[c]  <= on_len_next[c];
                off_len_reg[c] <= off_len_next[c];
                cycles_reg[c]  <= cycles_next[c];
            end
        end
    end

    // Channel control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                mode_reg[c]    <= MODE_TOGGLE;
                elapsed_reg[c] <= '0;
            end
            active_reg <= '0;
            phase_reg  <= '0;
            level_reg  <= '0;
        end
        else if (ctl.exec)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                mode_reg[c]    <= mode_next[c];
                elapsed_reg[c] <= elapsed_next[c];
            end
            active_reg <= active_next;
            phase_reg  <= phase_next;
            level_reg  <= level_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== sv/multichannel_relay_sequencer.sv =====
// Top level of the multichannel relay sequencer: controller plus datapath.
//
// Relay sequencer for up to eight channels, each set directly or run as a
// timer (seconds), a pulse (ms) or a blink (on/off ms and a cycle count),
// advanced by a 1 ms tick request. A request is taken into an input
// register, executed against all channels in parallel in the next cycle,
// and its result is held in an output register until taken. A new
// request is accepted in the same cycle that the previous result leaves,
// and none is taken while a request executes or its result is stalled.
// The controller's load and execute steps sequence each request over the
// shared channel update logic. Every request returns exactly one result.
module multichannel_relay_sequencer #(
    parameter int CHANNELS  = 8,
    parameter int TIME_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  mrs_pkg::request_t cmd,
    output logic              result_valid,
    input  logic              result_stall,
    output mrs_pkg::result_t  result
);
    import mrs_pkg::*;

    dp_ctl_t ctl;

    // Sequencing
    mrs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .ctl          (ctl)
    );

    // Channel state and execution
    mrs_datapath #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .cmd    (cmd),
        .result (result)
    );

endmodule
